// ===== hdl/crtm_pkg.sv =====
`default_nettype none

package crtm_pkg;

    // Field widths of the stream items.
    localparam int RULE_IDX_W = 6;
    localparam int MASK_W     = 36;
    localparam int STATE_W    = 2;
    localparam int NUM_POS    = 9;
    localparam int CELLS_W    = NUM_POS * STATE_W;
    localparam int RULE_W     = MASK_W + STATE_W;

    // Input tdata: rule_index, allowed_masks, rule_next, cells, zero pad.
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_MASK_LSB  = IN_IDX_LSB + RULE_IDX_W;
    localparam int IN_NEXT_LSB  = IN_MASK_LSB + MASK_W;
    localparam int IN_CELLS_LSB = IN_NEXT_LSB + STATE_W;
    localparam int S_TDATA_W    = 64;

    // Output tdata: next_cell, hit_index.
    localparam int M_TDATA_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int COUNT_W    = 7;

    localparam int NUM_STATES      = 4;
    localparam int MAX_RULES_DEFAULT = 64;

    // Mask bits for states at or above NUM_STATES are dropped at load.
    localparam logic [3:0] STATE_BITS =
        (NUM_STATES >= 4) ? 4'hF : 4'((1 << NUM_STATES) - 1);
    localparam logic [MASK_W-1:0] KEEP_MASK = {NUM_POS{STATE_BITS}};

    // Item kinds carried in the input tuser.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KIND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMMETRY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd2;

    // Neighbourhood kinds and symmetry modes.
    localparam logic       KIND_VON_NEUMANN = 1'b0;
    localparam logic       KIND_MOORE       = 1'b1;
    localparam logic [1:0] SYM_NONE         = 2'd0;
    localparam logic [1:0] SYM_QUARTER      = 2'd1;
    localparam logic [1:0] SYM_EIGHTH       = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_rule;   // a load beat is accepted
        logic capture;   // a lookup beat is accepted
        logic search;    // one step of the rule scan
        logic save_res;  // latch the scan result
        logic push;      // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;      // the scan has a result this cycle
        logic match;     // the rule checked this cycle matches
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/crtm_ram.sv =====
`default_nettype none

module crtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/crtm_datapath.sv =====
`default_nettype none

module crtm_datapath #(
    parameter int MAX_RULES = crtm_pkg::MAX_RULES_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [crtm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [crtm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [crtm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire crtm_pkg::t_dp_cmd               i_cmd,
    output crtm_pkg::t_dp_sts                    o_sts,
    output logic      [crtm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                                 o_m_tuser
);

    import crtm_pkg::*;

    localparam int ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int LIM_W  = ($clog2(MAX_RULES + 1) > COUNT_W) ? $clog2(MAX_RULES + 1) : COUNT_W;

    // One rule against one neighbourhood, all permitted rotations in parallel.
    function automatic logic rule_match(input logic [MASK_W-1:0] mask,
                                        input logic [CELLS_W-1:0] cells,
                                        input logic kind,
                                        input logic [1:0] sym);
        logic       c_ok;
        logic [7:0] ok_m;
        logic [3:0] ok_v;
        logic [7:0] en_m;
        logic [3:0] en_v;
        int         cp;
        c_ok = mask[int'(cells[STATE_W-1:0])];
        for (int r = 0; r < 8; r++) begin
            ok_m[r] = 1'b1;
            for (int i = 0; i < 8; i++) begin
                cp = 1 + ((i + r) & 7);
                ok_m[r] &= mask[4 * (1 + i) + int'(cells[STATE_W*cp +: STATE_W])];
            end
        end
        for (int r = 0; r < 4; r++) begin
            ok_v[r] = 1'b1;
            for (int i = 0; i < 4; i++) begin
                cp = 1 + 2 * ((i + r) & 3);
                ok_v[r] &= mask[4 * (1 + 2 * i) + int'(cells[STATE_W*cp +: STATE_W])];
            end
        end
        case (sym)
            SYM_QUARTER: begin
                en_m = 8'b0101_0101;
                en_v = 4'b1111;
            end
            SYM_EIGHTH: begin
                en_m = 8'b1111_1111;
                en_v = 4'b1111;
            end
            default: begin
                en_m = 8'b0000_0001;
                en_v = 4'b0001;
            end
        endcase
        if (kind == KIND_MOORE) begin
            return c_ok & (|(ok_m & en_m));
        end
        return c_ok & (|(ok_v & en_v));
    endfunction

    logic                  r_kind;
    logic [1:0]            r_sym;
    logic [COUNT_W-1:0]    r_count;
    logic [CELLS_W-1:0]    r_cells;
    logic [LIM_W-1:0]      r_addr;
    logic                  r_chk_valid;
    logic [LIM_W-1:0]      r_chk_idx;
    logic [STATE_W-1:0]    r_res_next;
    logic                  r_res_matched;
    logic [RULE_IDX_W-1:0] r_res_hit;
    logic [STATE_W-1:0]    r_out_next;
    logic                  r_out_matched;
    logic [RULE_IDX_W-1:0] r_out_hit;

    logic [RULE_IDX_W-1:0]    in_idx;
    logic [RULE_IDX_W+ADDR_W-1:0] wr_wide;
    logic                     wr_en;
    logic [RULE_W-1:0]        wr_data;
    logic [RULE_W-1:0]        rd_data;
    logic [LIM_W-1:0]         count_ext;
    logic [LIM_W-1:0]         limit;
    logic                     issue;
    logic                     hit;

    assign in_idx  = i_s_tdata[IN_IDX_LSB +: RULE_IDX_W];
    assign wr_wide = {{ADDR_W{1'b0}}, in_idx};
    assign wr_en   = i_cmd.wr_rule && (32'(in_idx) < MAX_RULES);
    assign wr_data = {i_s_tdata[IN_NEXT_LSB +: STATE_W],
                      i_s_tdata[IN_MASK_LSB +: MASK_W] & KEEP_MASK};

    // A rule count above the table size searches the whole table.
    // No further read is issued once a rule has matched, so the check stage
    // is empty whenever the scan is not running.
    assign count_ext = LIM_W'(r_count);
    assign limit     = (32'(r_count) > MAX_RULES) ? LIM_W'(MAX_RULES) : count_ext;
    assign issue     = i_cmd.search && !hit && (r_addr < limit);

    crtm_ram #(
        .WIDTH(RULE_W),
        .DEPTH(MAX_RULES)
    ) u_rules (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_wide[ADDR_W-1:0]),
        .i_wdata(wr_data),
        .i_re   (issue),
        .i_raddr(r_addr[ADDR_W-1:0]),
        .o_rdata(rd_data)
    );

    assign hit = r_chk_valid && rule_match(rd_data[MASK_W-1:0], r_cells, r_kind, r_sym);

    always_comb begin
        o_sts.match = hit;
        o_sts.done  = hit || (!r_chk_valid && !(r_addr < limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_MOORE;
            r_sym       <= SYM_NONE;
            r_count     <= '0;
            r_addr      <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_KIND:     r_kind  <= i_cfg_data[0];
                    REG_SYMMETRY: r_sym   <= i_cfg_data[1:0];
                    REG_COUNT:    r_count <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.capture) begin
                r_addr      <= '0;
                r_chk_valid <= 1'b0;
            end else if (i_cmd.search) begin
                r_chk_valid <= issue;
                if (issue) begin
                    r_addr <= r_addr + LIM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cells <= i_s_tdata[IN_CELLS_LSB +: CELLS_W];
        end
        if (i_cmd.search) begin
            r_chk_idx <= r_addr;
        end
        if (i_cmd.save_res) begin
            if (hit) begin
                r_res_next    <= rd_data[RULE_W-1 -: STATE_W];
                r_res_matched <= 1'b1;
                r_res_hit     <= r_chk_idx[RULE_IDX_W-1:0];
            end else begin
                r_res_next    <= r_cells[STATE_W-1:0];
                r_res_matched <= 1'b0;
                r_res_hit     <= '0;
            end
        end
        if (i_cmd.push) begin
            r_out_next    <= r_res_next;
            r_out_matched <= r_res_matched;
            r_out_hit     <= r_res_hit;
        end
    end

    assign o_m_tdata = {r_out_hit, r_out_next};
    assign o_m_tuser = r_out_matched;

endmodule

`default_nettype wire

// ===== hdl/crtm_ctrl.sv =====
`default_nettype none

module crtm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tuser,
    input  wire logic              i_m_tready,
    input  wire crtm_pkg::t_dp_sts i_sts,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    output crtm_pkg::t_dp_cmd      o_cmd
);

    import crtm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_PUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;
    logic   accept;
    logic   out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    always_comb begin
        n_state       = r_state;
        n_m_valid     = r_m_valid && !i_m_tready;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.wr_rule = accept && (i_s_tuser == CMD_LOAD);
                o_cmd.capture = accept && (i_s_tuser == CMD_LOOKUP);
                if (o_cmd.capture) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.done) begin
                    o_cmd.save_res = 1'b1;
                    n_state        = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    o_cmd.push = 1'b1;
                    n_m_valid  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_tvalid = r_m_valid;

endmodule

`default_nettype wire

// ===== hdl/ca_rule_table_matcher.sv =====
`default_nettype none

// Channel     Dir  Handshake                      Payload
// s_axis      in   s_axis_tvalid / s_axis_tready  tdata: rule items and lookups, tuser: cmd
// m_axis      out  m_axis_tvalid / m_axis_tready  tdata: next_cell, hit_index; tuser: matched
// cfg         in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// A load beat writes one rule RAM slot if its rule_index is below MAX_RULES.
// A lookup scans the rules at one RAM read per cycle and stops at the first match
// or after n rules, n being rule_count capped at MAX_RULES; the next beat can be
// taken once the result has been moved into the output register. Reset is
// synchronous, active low; it clears the controller, config and scan registers,
// not the result registers or rule RAM. Configuration writes are always taken.
// The finished result sits in the output register while the next beat is taken;
// a stalled output only holds a later lookup before its result is moved out.

module ca_rule_table_matcher #(
    parameter int MAX_RULES = crtm_pkg::MAX_RULES_DEFAULT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] rule_index, [41:6] allowed_masks, [43:42] rule_next, [61:44] cells
    input  wire logic [crtm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [1:0] next_cell, [7:2] hit_index
    output logic      [crtm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // [0] matched
    output logic                                 m_axis_tuser,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [crtm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [crtm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import crtm_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    crtm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tuser (s_axis_tuser),
        .i_m_tready(m_axis_tready),
        .i_sts     (dp_sts),
        .o_s_tready(s_axis_tready),
        .o_m_tvalid(m_axis_tvalid),
        .o_cmd     (dp_cmd)
    );

    crtm_datapath #(
        .MAX_RULES(MAX_RULES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(cfg_write),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (s_axis_tdata),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

    // A lookup closes the input until its result has been moved out.
    a_lookup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOOKUP))
        |=> !s_axis_tready)
        else $error("input still open after a lookup beat");

    // The rule RAM is never written while a scan reads it.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.search |-> !dp_cmd.wr_rule && !s_axis_tready)
        else $error("rule write during a scan");

    // A result appears on the output only after a push from the controller.
    a_valid_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(dp_cmd.push))
        else $error("output valid without a push");

    // A match can only be reported while a scan is running.
    a_match_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_sts.match && !dp_cmd.search |-> 1'b0)
        else $error("match reported outside a scan");

endmodule

`default_nettype wire
